[hdl/held_note_drone_register_top_assert.svh]
// Assertion macros for the held-note drone register.
// Each macro checks on the rising edge of clock and is off while reset is high.
`ifndef HELD_NOTE_DRONE_REGISTER_TOP_ASSERT_SVH
`define HELD_NOTE_DRONE_REGISTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define HNDR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define HNDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HNDR_ASSERT_SAME(label, ante, cons, msg)
`define HNDR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hdl/hndr_pkg.sv]
package hndr_pkg;

   localparam int MAX_HELD_DEFAULT           = 8;
   localparam int UPPER_MIN_INTERVAL_DEFAULT = 7;

   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int OP_W    = 2;
   localparam int TOTAL_W = 4;

   localparam logic [NOTE_W-1:0] DRONE_RESET = NOTE_W'(38);

   // event kinds
   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_SHIFT,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SEARCH,
      CMD_APPLY,
      CMD_SHIFT,
      CMD_SCAN_INIT,
      CMD_SCAN,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic idx_end;       // walk index reached the held count
      logic shift_needed;  // note off hit a held entry
      logic out_free;      // result register can take a new result
   } status_type;

   // result fields, gate_on in the lowest bit
   typedef struct packed {
      logic [TOTAL_W-1:0] held_total;
      logic               drone_changed;
      logic               fresh_attack;
      logic [VEL_W-1:0]   attack_velocity;
      logic [NOTE_W-1:0]  upper_out;
      logic               upper_valid;
      logic [NOTE_W-1:0]  drone_out;
      logic               gate_on;
   } rsp_fields_type;

endpackage

[hdl/hndr_dp.sv]
module hndr_dp
   import hndr_pkg::*;
#(
   parameter int MAX_HELD           = MAX_HELD_DEFAULT,
   parameter int UPPER_MIN_INTERVAL = UPPER_MIN_INTERVAL_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [OP_W-1:0]   req_op,
   input  logic [NOTE_W-1:0] req_note,
   input  logic [VEL_W-1:0]  req_velocity,
   output logic              rsp_valid,
   input  logic              rsp_tready,
   output rsp_fields_type    rsp_fields
);

   localparam int CW = $clog2(MAX_HELD + 1);
   localparam int IW = $clog2(MAX_HELD);

   logic [NOTE_W-1:0] list_ff [MAX_HELD];
   logic              list_we;
   logic [IW-1:0]     list_waddr;
   logic [NOTE_W-1:0] list_wdata;
   logic [CW-1:0]     rd_addr;
   logic [NOTE_W-1:0] rd_data;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic              found_ff, found_in;
   logic [NOTE_W-1:0] lo_ff, lo_in;
   logic [NOTE_W-1:0] hi_ff, hi_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              gate_ff, gate_in;
   logic [NOTE_W-1:0] drone_ff, drone_in;
   logic [VEL_W-1:0]  latvel_ff, latvel_in;
   logic              fresh_ff, fresh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_fields_type    rsp_ff, rsp_in;
   logic              up_valid;
   logic [NOTE_W-1:0] span;

   // shift reads the entry above the one being written
   assign rd_addr = (cmd == CMD_SHIFT) ? idx_ff + CW'(1) : idx_ff;
   assign rd_data = list_ff[rd_addr[IW-1:0]];
   assign span    = hi_ff - lo_ff;

   always_comb begin
      op_in        = op_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      gate_in      = gate_ff;
      drone_in     = drone_ff;
      latvel_in    = latvel_ff;
      fresh_in     = fresh_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      list_we      = 1'b0;
      list_waddr   = idx_ff[IW-1:0];
      list_wdata   = rd_data;
      up_valid     = 1'b0;
      unique case (cmd)
         CMD_NONE: begin
         end
         CMD_LOAD: begin
            op_in    = req_op;
            note_in  = req_note;
            vel_in   = req_velocity;
            idx_in   = '0;
            found_in = 1'b0;
         end
         CMD_SEARCH: begin
            if (rd_data == note_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff[IW-1:0];
            end
            idx_in = idx_ff + CW'(1);
         end
         CMD_APPLY: begin
            fresh_in = 1'b0;
            unique case (op_ff)
               OP_NOTE_ON: begin
                  fresh_in = !gate_ff;
                  gate_in  = 1'b1;
                  if (!gate_ff) begin
                     latvel_in = vel_ff;
                  end
                  if (!found_ff && count_ff < CW'(MAX_HELD)) begin
                     list_we    = 1'b1;
                     list_waddr = count_ff[IW-1:0];
                     list_wdata = note_ff;
                     count_in   = count_ff + CW'(1);
                  end
               end
               OP_NOTE_OFF: begin
                  if (found_ff) begin
                     count_in = count_ff - CW'(1);
                     gate_in  = (count_ff != CW'(1));
                     idx_in   = CW'(pos_ff);
                  end else begin
                     gate_in = (count_ff != '0);
                  end
               end
               OP_ALL_OFF: begin
                  count_in = '0;
                  gate_in  = 1'b0;
               end
               default: begin
               end
            endcase
         end
         CMD_SHIFT: begin
            list_we    = 1'b1;
            list_waddr = idx_ff[IW-1:0];
            list_wdata = rd_data;
            idx_in     = idx_ff + CW'(1);
         end
         CMD_SCAN_INIT: begin
            idx_in = '0;
            lo_in  = '1;
            hi_in  = '0;
         end
         CMD_SCAN: begin
            if (rd_data < lo_ff) begin
               lo_in = rd_data;
            end
            if (rd_data > hi_ff) begin
               hi_in = rd_data;
            end
            idx_in = idx_ff + CW'(1);
         end
         CMD_FINISH: begin
            rsp_in.drone_changed = 1'b0;
            if (count_ff != '0) begin
               drone_in             = lo_ff;
               rsp_in.drone_changed = (lo_ff != drone_ff);
               up_valid             = (span >= NOTE_W'(UPPER_MIN_INTERVAL));
            end
            rsp_in.gate_on         = gate_ff;
            rsp_in.drone_out       = drone_in;
            rsp_in.upper_valid     = up_valid;
            rsp_in.upper_out       = up_valid ? hi_ff : '0;
            rsp_in.attack_velocity = latvel_ff;
            rsp_in.fresh_attack    = fresh_ff;
            rsp_in.held_total      = TOTAL_W'(count_ff);
            rsp_valid_in           = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_ff[list_waddr] <= list_wdata;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      note_ff  <= note_in;
      vel_ff   <= vel_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      fresh_ff <= fresh_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gate_ff      <= 1'b0;
         drone_ff     <= DRONE_RESET;
         latvel_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         gate_ff      <= gate_in;
         drone_ff     <= drone_in;
         latvel_ff    <= latvel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.idx_end      = (idx_ff >= count_ff);
   assign status.shift_needed = (op_ff == OP_NOTE_OFF) && found_ff;
   assign status.out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fields          = rsp_ff;

endmodule

[hdl/hndr_ctrl.sv]
module hndr_ctrl
   import hndr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_SEARCH;
         ST_SEARCH:    if (status.idx_end) state_in = ST_APPLY;
         ST_APPLY:     state_in = status.shift_needed ? ST_SHIFT : ST_SCAN_INIT;
         ST_SHIFT:     if (status.idx_end) state_in = ST_SCAN_INIT;
         ST_SCAN_INIT: state_in = ST_SCAN;
         ST_SCAN:      if (status.idx_end) state_in = ST_FINISH;
         ST_FINISH:    if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd = CMD_LOAD;
         end
         ST_SEARCH:    if (!status.idx_end) cmd = CMD_SEARCH;
         ST_APPLY:     cmd = CMD_APPLY;
         ST_SHIFT:     if (!status.idx_end) cmd = CMD_SHIFT;
         ST_SCAN_INIT: cmd = CMD_SCAN_INIT;
         ST_SCAN:      if (!status.idx_end) cmd = CMD_SCAN;
         ST_FINISH:    if (status.out_free) cmd = CMD_FINISH;
         default:      cmd = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/held_note_drone_register_top.sv]
// Channel   Dir  Payload
// req_      in   tuser: op; tdata: note, velocity
// rsp_      out  tdata: gate_on, drone_out, upper_valid, upper_out, attack_velocity,
//                       fresh_attack, drone_changed, held_total
//
// One event is worked at a time. From the accepting edge to the result load it walks
// the N held notes before the event (search walk), then, for a note off that removes a
// held note, shifts the entries above it down, then walks the M held notes after it
// (min/max walk). All walks go one list entry per cycle through a single read port.
// Reset (synchronous, high) empties the list, closes the gate, sets the drone to 38.
// The result register lets the next event in while a result waits; a stalled result
// only holds the controller in its final state.
`include "held_note_drone_register_top_assert.svh"

module held_note_drone_register_top
   import hndr_pkg::*;
#(
   parameter int MAX_HELD           = MAX_HELD_DEFAULT,
   parameter int UPPER_MIN_INTERVAL = UPPER_MIN_INTERVAL_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [6:0] note, [13:7] velocity, [15:14] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [0] gate_on, [7:1] drone_out, [8] upper_valid,
                                    // [15:9] upper_out, [22:16] attack_velocity,
                                    // [23] fresh_attack, [24] drone_changed,
                                    // [28:25] held_total, [31:29] zero
);

   cmd_type        cmd;
   status_type     status;
   rsp_fields_type rsp_fields;

   // sequencer: walks search, update, shift, scan and result load
   hndr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // note list, gate/drone state and the result register
   hndr_dp #(
      .MAX_HELD           (MAX_HELD),
      .UPPER_MIN_INTERVAL (UPPER_MIN_INTERVAL)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_tuser),
      .req_note     (req_tdata[6:0]),
      .req_velocity (req_tdata[13:7]),
      .rsp_valid    (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_fields   (rsp_fields)
   );

   assign rsp_tdata = {3'b000, rsp_fields};

   // a fresh attack always leaves the gate open
   `HNDR_ASSERT_SAME(a_fresh_gate, rsp_tvalid && rsp_fields.fresh_attack, rsp_fields.gate_on, "fresh attack with gate closed")
   // an upper note needs at least one held note
   `HNDR_ASSERT_SAME(a_upper_gate, rsp_tvalid && rsp_fields.upper_valid, rsp_fields.gate_on, "upper note with gate closed")
   // one event at a time: busy right after a transfer in
   `HNDR_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "second event taken while busy")

endmodule

[dv/tb.sv]
module tb;
   import hndr_pkg::*;

   // unused event code: list and gate stay as they are, a result still comes back
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam int EVENT_TARGET = 1550;
   localparam int REPORT_MAX   = 10;
   localparam int DRAIN_CYCLES = 60;       // well above the slowest event latency
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  vel;
      bit                drain;            // hold this one back until all results are in
   } note_event_type;

   // ---------------------------------------------------------------- DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;          // [6:0] note, [13:7] velocity, [15:14] zero
   logic [1:0]  req_tuser  = '0;          // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;                // packed rsp_fields_type in [28:0], gate_on lowest

   held_note_drone_register_top #(
      .MAX_HELD           (MAX_HELD_DEFAULT),
      .UPPER_MIN_INTERVAL (UPPER_MIN_INTERVAL_DEFAULT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shared state
   note_event_type note_events_pending[$];     // filled up front, drained by the driver
   rsp_fields_type voice_results_due[$];       // predicted results, oldest first

   int  cycle_count     = 0;
   int  events_accepted = 0;
   int  results_checked = 0;
   int  mismatch_count  = 0;
   int  error_count     = 0;
   int  ops_seen[4]     = '{0, 0, 0, 0};
   int  fresh_seen      = 0;
   int  upper_seen      = 0;
   int  full_drops      = 0;
   bit  req_taken       = 1'b0;               // transfer on req_ at the last rising edge

   // ---------------------------------------------------------------- voice stack mirror
   logic [NOTE_W-1:0] stack_notes [MAX_HELD_DEFAULT];
   logic [VEL_W-1:0]  stack_vels  [MAX_HELD_DEFAULT];
   int                stack_depth;
   bit                gate_open;
   logic [NOTE_W-1:0] drone_note;
   bit                upper_sel;
   logic [NOTE_W-1:0] upper_note;
   logic [VEL_W-1:0]  attack_vel;

   task automatic clear_voice_stack();
      stack_depth = 0;
      gate_open   = 1'b0;
      drone_note  = DRONE_RESET;
      upper_sel   = 1'b0;
      upper_note  = '0;
      attack_vel  = '0;
   endtask

   // Applies one event to the mirror and returns what the block should report.
   function automatic rsp_fields_type predict_voice(logic [OP_W-1:0] op,
                                                    logic [NOTE_W-1:0] note,
                                                    logic [VEL_W-1:0] vel);
      rsp_fields_type    r;
      int                slot;
      logic [NOTE_W-1:0] lo, hi;
      bit                fresh;
      bit                moved;
      fresh = 1'b0;
      moved = 1'b0;
      if (op == OP_NOTE_ON) begin
         slot = -1;
         for (int i = 0; i < stack_depth; i++)
            if (stack_notes[i] == note) slot = i;
         if (slot < 0 && stack_depth < MAX_HELD_DEFAULT) begin
            slot = stack_depth;
            stack_depth++;
         end
         if (slot >= 0) begin
            stack_notes[slot] = note;
            stack_vels[slot]  = vel;
         end else begin
            full_drops++;
         end
         if (!gate_open) begin
            attack_vel = vel;
            fresh      = 1'b1;
         end
         gate_open = 1'b1;
      end else if (op == OP_NOTE_OFF) begin
         for (int i = 0; i < stack_depth; i++) begin
            if (stack_notes[i] == note) begin
               for (int j = i; j + 1 < stack_depth; j++) begin
                  stack_notes[j] = stack_notes[j+1];
                  stack_vels[j]  = stack_vels[j+1];
               end
               stack_depth--;
               break;
            end
         end
         gate_open = (stack_depth > 0);
      end else if (op == OP_ALL_OFF) begin
         stack_depth = 0;
         gate_open   = 1'b0;
      end

      // lowest held note drives the drone; drone holds when the list empties
      if (stack_depth == 0) begin
         upper_sel  = 1'b0;
         upper_note = '0;
      end else begin
         lo = stack_notes[0];
         hi = stack_notes[0];
         for (int i = 1; i < stack_depth; i++) begin
            if (stack_notes[i] < lo) lo = stack_notes[i];
            if (stack_notes[i] > hi) hi = stack_notes[i];
         end
         moved      = (lo != drone_note);
         drone_note = lo;
         if (hi != lo && int'(hi) - int'(lo) >= UPPER_MIN_INTERVAL_DEFAULT) begin
            upper_sel  = 1'b1;
            upper_note = hi;
         end else begin
            upper_sel  = 1'b0;
            upper_note = '0;
         end
      end

      r.gate_on         = gate_open;
      r.drone_out       = drone_note;
      r.upper_valid     = upper_sel;
      r.upper_out       = upper_sel ? upper_note : '0;
      r.attack_velocity = attack_vel;
      r.fresh_attack    = fresh;
      r.drone_changed   = moved;
      r.held_total      = stack_depth[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("MISMATCH result %0d %s: expected %0d, got %0d",
                     results_checked, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------- monitor
   // Samples both channels on the rising edge; inputs only move on the falling edge.
   always @(posedge clock) begin
      rsp_fields_type want;
      rsp_fields_type got;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         clear_voice_stack();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            want = predict_voice(req_tuser, req_tdata[6:0], req_tdata[13:7]);
            voice_results_due.push_back(want);
            events_accepted <= events_accepted + 1;
            ops_seen[req_tuser]++;
            if (want.fresh_attack) fresh_seen++;
            if (want.upper_valid) upper_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_fields_type'(rsp_tdata[28:0]);
            if (voice_results_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("ERROR result with nothing pending: tdata %h", rsp_tdata);
            end else begin
               want = voice_results_due.pop_front();
               check_field("gate_on",         want.gate_on,         got.gate_on);
               check_field("drone_out",       want.drone_out,       got.drone_out);
               check_field("upper_valid",     want.upper_valid,     got.upper_valid);
               check_field("upper_out",       want.upper_out,       got.upper_out);
               check_field("attack_velocity", want.attack_velocity, got.attack_velocity);
               check_field("fresh_attack",    want.fresh_attack,    got.fresh_attack);
               check_field("drone_changed",   want.drone_changed,   got.drone_changed);
               check_field("held_total",      want.held_total,      got.held_total);
            end
            results_checked <= results_checked + 1;
         end
      end
   end

   // ---------------------------------------------------------------- driver
   // Bursts of offered events with random gaps; a drain-marked event waits for
   // every outstanding result before it goes out.
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      note_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (note_events_pending.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (note_events_pending[0].drain && voice_results_due.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            ev = note_events_pending.pop_front();
            req_tuser  <= ev.op;
            req_tdata  <= {2'b00, ev.vel, ev.note};
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // Ready pattern switches between open, patchy and mostly stalled stretches.
   // Once, a long hold-off lets the result register and controller back up.
   int rx_mode      = 0;
   int rx_mode_left = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && events_accepted >= 400) begin
            hold_done = 1'b1;
            hold_left = 500;
         end
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 200);
         end else begin
            rx_mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_event(logic [OP_W-1:0] op, int note, int vel, bit drain = 1'b0);
      note_event_type ev;
      ev.op    = op;
      ev.note  = note[NOTE_W-1:0];
      ev.vel   = vel[VEL_W-1:0];
      ev.drain = drain;
      note_events_pending.push_back(ev);
   endtask

   task automatic build_directed();
      push_event(OP_NOTE_OFF, 60, 17);      // off on empty list: drone stays at reset
      push_event(OP_ALL_OFF, 0, 0);
      push_event(OP_SPARE, 127, 127);       // spare code on empty list
      push_event(OP_NOTE_ON, 0, 127);       // opens gate, drone to lowest note
      push_event(OP_NOTE_ON, 127, 0);       // wide span: upper note
      push_event(OP_NOTE_ON, 0, 55);        // refresh of a held note, no append
      push_event(OP_NOTE_OFF, 0, 0);        // drone moves up, upper drops
      push_event(OP_NOTE_ON, 120, 1);       // span of exactly the minimum interval
      push_event(OP_NOTE_ON, 121, 90);
      push_event(OP_NOTE_OFF, 120, 0);      // span one short of the interval
      push_event(OP_NOTE_ON, 10, 10);
      push_event(OP_NOTE_ON, 20, 20);
      push_event(OP_NOTE_ON, 30, 30);
      push_event(OP_NOTE_ON, 40, 40);
      push_event(OP_NOTE_ON, 50, 50);
      push_event(OP_NOTE_ON, 60, 60);       // list now full
      push_event(OP_NOTE_ON, 5, 77);        // new note on a full list is dropped
      push_event(OP_NOTE_ON, 30, 99);       // refresh while full
      push_event(OP_NOTE_OFF, 10, 0);       // removal from the middle, later entries shift
      push_event(OP_SPARE, 3, 64);          // spare code with notes held
      push_event(OP_NOTE_OFF, 99, 0);       // off for a note not held
      push_event(OP_ALL_OFF, 42, 42);       // drone kept, gate closes
      push_event(OP_NOTE_ON, 127, 127, 1'b1);
      push_event(OP_NOTE_OFF, 127, 0);      // last note released by note off
      push_event(OP_NOTE_ON, 64, 85);
   endtask

   // Phases of events on a small note pool so that offs hit held notes and the
   // list fills; some pools are clustered to sit around the upper interval.
   task automatic build_random();
      int pool[$];
      int pool_size, base, phase_len, phase_no, pick;
      phase_no = 0;
      while (note_events_pending.size() < EVENT_TARGET) begin
         pool.delete();
         pool_size = $urandom_range(2, 12);
         base      = $urandom_range(0, 117);
         for (int i = 0; i < pool_size; i++)
            pool.push_back((phase_no % 4 == 1) ? base + $urandom_range(0, 10)
                                               : $urandom_range(0, 127));
         phase_len = $urandom_range(40, 120);
         for (int k = 0; k < phase_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
               push_event(OP_NOTE_ON, pool[$urandom_range(0, pool_size - 1)],
                          $urandom_range(0, 127), (k == 0 && phase_no % 3 == 2));
            else if (pick < 86)
               push_event(OP_NOTE_OFF, pool[$urandom_range(0, pool_size - 1)],
                          $urandom_range(0, 127));
            else if (pick < 92)
               push_event(OP_NOTE_OFF, $urandom_range(0, 127), $urandom_range(0, 127));
            else if (pick < 97)
               push_event(OP_ALL_OFF, $urandom_range(0, 127), $urandom_range(0, 127));
            else
               push_event(OP_SPARE, $urandom_range(0, 127), $urandom_range(0, 127));
         end
         phase_no++;
      end
   endtask

   // ---------------------------------------------------------------- sequencing
   initial begin
      build_directed();
      build_random();
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (note_events_pending.size() != 0 || req_tvalid)
         @(posedge clock);
      while (voice_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results over %0d events: %0d on, %0d off, %0d all-off, %0d spare",
               results_checked, events_accepted, ops_seen[OP_NOTE_ON], ops_seen[OP_NOTE_OFF],
               ops_seen[OP_ALL_OFF], ops_seen[OP_SPARE]);
      $display("Fresh attacks %0d, upper notes %0d, full-list drops %0d, one long rx hold-off",
               fresh_seen, upper_seen, full_drops);
      if (mismatch_count == 0 && error_count == 0 && voice_results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d unexpected results, %0d still pending",
                  mismatch_count, error_count, voice_results_due.size());
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, voice_results_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
